// ----- design/abpw_pkg.sv -----
package abpw_pkg;

  localparam int DISP_COLS_DEF   = 1024;
  localparam int DISP_ROWS_DEF   = 768;
  localparam int STORE_DEPTH_DEF = 1048576;

  localparam int POS_W     = 12;
  localparam int COORD_W   = 10;
  localparam int STRIDE_W  = 11;
  localparam int COLOR_W   = 24;
  localparam int ALPHA_W   = 8;
  localparam int CHAN_W    = 8;
  // y*stride + x stays below 2^22 for on-screen positions
  localparam int LIN_W     = 22;
  localparam int QUO_W     = 12;
  localparam int RECIP_SHIFT = 32;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd1024;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_NONE   = 8'd0;
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic                     kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [COLOR_W-1:0]       pixel_color;
    logic [ALPHA_W-1:0]       alpha;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               in_bounds;
    logic               stored;
  } out_item_t;

  // classified operation handed from the front end to the back end
  typedef struct packed {
    logic               is_read;
    logic               in_bounds;
    logic               do_write;
    logic               do_blend;
    logic [COLOR_W-1:0] color;
    logic [ALPHA_W-1:0] alpha;
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_EXEC
  } back_state_t;

  function automatic logic [CHAN_W-1:0] blend_channel(
    input logic [CHAN_W-1:0]  fg,
    input logic [CHAN_W-1:0]  bg,
    input logic [ALPHA_W-1:0] a
  );
    logic [ALPHA_W:0]          wf;
    logic [ALPHA_W:0]          wb;
    logic [ALPHA_W+CHAN_W+1:0] sum;
    wf  = {1'b0, a} + 9'd1;
    wb  = 9'd256 - {1'b0, a};
    sum = (ALPHA_W+CHAN_W+2)'(wf) * (ALPHA_W+CHAN_W+2)'(fg) +
          (ALPHA_W+CHAN_W+2)'(wb) * (ALPHA_W+CHAN_W+2)'(bg);
    return sum[CHAN_W +: CHAN_W];
  endfunction

endpackage

// ----- design/abpw_queue.sv -----
module abpw_queue #(
  parameter int DEPTH = abpw_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

// ----- design/abpw_front.sv -----
module abpw_front #(
  parameter int DISP_COLS   = abpw_pkg::DISP_COLS_DEF,
  parameter int DISP_ROWS   = abpw_pkg::DISP_ROWS_DEF,
  parameter int STORE_DEPTH = abpw_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [abpw_pkg::STRIDE_W-1:0]   cfg_wr_data,
  input  logic                            accept,
  input  abpw_pkg::in_item_t              in_data,
  output logic                            push,
  output abpw_pkg::op_t                   push_op,
  output logic [AW-1:0]                   push_addr,
  output logic [1:0]                      in_flight
);

  localparam int LW = abpw_pkg::LIN_W;
  localparam int QW = abpw_pkg::QUO_W;
  localparam int PW = 2*LW + 1;
  localparam logic [LW:0] RECIP = (LW+1)'((64'd1 << abpw_pkg::RECIP_SHIFT) / STORE_DEPTH);

  logic [abpw_pkg::STRIDE_W-1:0] stride_r;

  logic               s1_v_r, s2_v_r, s3_v_r;
  abpw_pkg::in_item_t s1_item_r;
  abpw_pkg::op_t      s1_op, s2_op_r, s3_op_r;
  logic [LW-1:0]      s1_lin, s2_lin_r, s3_lin_r;
  logic [QW-1:0]      s2_quo, s3_quo_r;

  logic               x_ok, y_ok;
  logic [PW-1:0]      recip_prod;
  logic [LW-1:0]      quo_times_d;
  logic [LW-1:0]      rem0, rem1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= abpw_pkg::STRIDE_RESET;
    end else if (cfg_wr_en) begin
      stride_r <= cfg_wr_data;
    end
  end

  // stage 1: bounds check, classification, linear address
  always_comb begin
    x_ok = !s1_item_r.pos_x[abpw_pkg::POS_W-1] &&
           (s1_item_r.pos_x[abpw_pkg::POS_W-2:0] < (abpw_pkg::POS_W-1)'(DISP_COLS));
    y_ok = !s1_item_r.pos_y[abpw_pkg::POS_W-1] &&
           (s1_item_r.pos_y[abpw_pkg::POS_W-2:0] < (abpw_pkg::POS_W-1)'(DISP_ROWS));
    s1_lin = LW'(s1_item_r.pos_y[abpw_pkg::COORD_W-1:0]) * LW'(stride_r) +
             LW'(s1_item_r.pos_x[abpw_pkg::COORD_W-1:0]);
    s1_op.is_read   = (s1_item_r.kind == abpw_pkg::KIND_READ);
    s1_op.in_bounds = x_ok && y_ok;
    s1_op.do_write  = x_ok && y_ok && (s1_item_r.kind == abpw_pkg::KIND_WRITE) &&
                      (s1_item_r.alpha != abpw_pkg::ALPHA_NONE);
    s1_op.do_blend  = s1_op.do_write && (s1_item_r.alpha != abpw_pkg::ALPHA_OPAQUE);
    s1_op.color     = s1_item_r.pixel_color;
    s1_op.alpha     = s1_item_r.alpha;
  end

  // stage 2: quotient estimate by reciprocal, low by at most one
  assign recip_prod = PW'(s2_lin_r) * PW'(RECIP);
  assign s2_quo     = recip_prod[abpw_pkg::RECIP_SHIFT +: QW];

  // stage 3: remainder with one correction step
  always_comb begin
    quo_times_d = LW'(s3_quo_r) * LW'(STORE_DEPTH);
    rem0        = s3_lin_r - quo_times_d;
    rem1        = (rem0 >= LW'(STORE_DEPTH)) ? rem0 - LW'(STORE_DEPTH) : rem0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    s2_op_r  <= s1_op;
    s2_lin_r <= s1_lin;
    s3_op_r  <= s2_op_r;
    s3_lin_r <= s2_lin_r;
    s3_quo_r <= s2_quo;
  end

  assign push      = s3_v_r;
  assign push_op   = s3_op_r;
  assign push_addr = AW'(rem1);
  assign in_flight = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);

endmodule

// ----- design/abpw_back.sv -----
module abpw_back #(
  parameter int STORE_DEPTH = abpw_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  abpw_pkg::op_t        q_op,
  input  logic [AW-1:0]        q_addr,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  output abpw_pkg::out_item_t  out_data
);

  localparam int CW = abpw_pkg::COLOR_W;
  localparam int BW = abpw_pkg::CHAN_W;

  logic [CW-1:0] mem [STORE_DEPTH];

  abpw_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]       clr_r;
  abpw_pkg::op_t       op_r;
  logic [AW-1:0]       addr_r;
  logic [CW-1:0]       rd_data_r;
  logic                out_valid_r;
  abpw_pkg::out_item_t out_data_r;

  logic                rd_en;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [CW-1:0]       wr_data;
  logic                emit;
  logic [CW-1:0]       blended;
  abpw_pkg::out_item_t result;

  always_comb begin
    for (int c = 0; c < CW/BW; c++) begin
      blended[c*BW +: BW] = abpw_pkg::blend_channel(op_r.color[c*BW +: BW],
                                                     rd_data_r[c*BW +: BW], op_r.alpha);
    end
  end

  always_comb begin
    result.read_color = (op_r.is_read && op_r.in_bounds) ? rd_data_r : '0;
    result.in_bounds  = op_r.in_bounds;
    result.stored     = op_r.do_write;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      abpw_pkg::BK_CLEAR: begin
        if (clr_r == AW'(STORE_DEPTH-1)) begin
          state_nxt = abpw_pkg::BK_IDLE;
        end
      end
      abpw_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = abpw_pkg::BK_READ;
        end
      end
      abpw_pkg::BK_READ: begin
        state_nxt = abpw_pkg::BK_EXEC;
      end
      abpw_pkg::BK_EXEC: begin
        state_nxt = q_empty ? abpw_pkg::BK_IDLE : abpw_pkg::BK_READ;
      end
      default: begin
        state_nxt = abpw_pkg::BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    clearing = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = addr_r;
    wr_data  = op_r.color;
    emit     = 1'b0;
    case (state_r)
      abpw_pkg::BK_CLEAR: begin
        clearing = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = clr_r;
        wr_data  = '0;
      end
      abpw_pkg::BK_IDLE: begin
        q_pop = !q_empty;
      end
      abpw_pkg::BK_READ: begin
        rd_en = 1'b1;
      end
      abpw_pkg::BK_EXEC: begin
        q_pop = !q_empty;
        emit  = 1'b1;
        wr_en = op_r.do_write;
        if (op_r.do_blend) begin
          wr_data = blended;
        end
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abpw_pkg::BK_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (state_r == abpw_pkg::BK_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r   <= q_op;
      addr_r <= q_addr;
    end
    if (emit) begin
      out_data_r <= result;
    end
  end

  // pixel store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/alpha_blend_pixel_writer.sv -----
// path: an accepted item runs through the front-end stages and the queue, then the back end's read and exec states
// the back end handles one item at a time (read the pixel, then blend and write back);
//   the front end and a 4-entry queue accept items ahead of that
// reset: synchronous, active low; afterwards busy stays high
//   while the store is zeroed one word per cycle; cfg writes are taken during that time
// every item yields one result beat, held for one cycle; the receiver cannot stall
module alpha_blend_pixel_writer #(
  parameter int DISP_COLS   = abpw_pkg::DISP_COLS_DEF,
  parameter int DISP_ROWS   = abpw_pkg::DISP_ROWS_DEF,
  parameter int STORE_DEPTH = abpw_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [abpw_pkg::STRIDE_W-1:0]  cfg_wr_data,
  input  logic                           start,
  output logic                           busy,
  input  abpw_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output abpw_pkg::out_item_t            out_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int QD = abpw_pkg::QUEUE_DEPTH;
  localparam int EW = $bits(abpw_pkg::op_t) + AW;
  localparam int CW = $clog2(QD+1);

  logic                accept;
  logic                push;
  abpw_pkg::op_t       push_op;
  logic [AW-1:0]       push_addr;
  logic [1:0]          in_flight;
  logic                q_pop;
  logic                q_empty;
  logic [CW-1:0]       q_count;
  logic [EW-1:0]       q_data;
  abpw_pkg::op_t       q_op;
  logic [AW-1:0]       q_addr;
  logic                clearing;
  logic [CW:0]         occupancy;

  // queue entries plus beats still in the front end must leave room for one more
  assign occupancy = (CW+1)'(q_count) + (CW+1)'(in_flight);
  assign busy      = clearing || (occupancy >= (CW+1)'(QD));
  assign accept    = start && !busy;

  abpw_front #(
    .DISP_COLS   (DISP_COLS),
    .DISP_ROWS   (DISP_ROWS),
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_data     (in_data),
    .push        (push),
    .push_op     (push_op),
    .push_addr   (push_addr),
    .in_flight   (in_flight)
  );

  abpw_queue #(
    .DEPTH (QD),
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_op, push_addr}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  assign q_op   = abpw_pkg::op_t'(q_data[EW-1:AW]);
  assign q_addr = q_data[AW-1:0];

  abpw_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_op      (q_op),
    .q_addr    (q_addr),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
